FILE: sv/smi_pkg.sv
// Shared types, widths and cofactor operand tables for the small matrix inverse block.
package smi_pkg;

  // Entry and result formats.
  localparam int unsigned EW = 16;            // entry width, signed Q8.8
  localparam int unsigned EF = EW / 2;        // entry fraction bits
  localparam int unsigned RW = 32;            // inverse entry width, signed Q16.16
  localparam int unsigned RF = RW / 2;        // inverse fraction bits
  localparam int unsigned DW = 52;            // determinant width, signed Q28.24
  localparam int unsigned CW = 2 * EW + 1;    // cofactor width
  localparam int unsigned TW = EW + CW;       // entry times cofactor width
  localparam int unsigned NW = CW + EF + RF;  // dividend magnitude width
  localparam int unsigned QW = RW + 1;        // quotient bits produced by a lane
  localparam int unsigned NE = 9;             // entries per matrix
  localparam int unsigned NP = 2 * NE;        // two-term products per matrix

  // Order register codes.
  localparam logic [1:0] ORDER_2X2 = 2'd2;
  localparam logic [1:0] ORDER_RESET = 2'd3;

  // Cofactor k is prod[2k] - prod[2k+1]; entries are row-major indexes.
  localparam int unsigned OP_A [NP] = '{4, 7, 7, 1, 1, 4, 6, 3, 0, 6, 3, 0, 3, 6, 6, 0, 0, 3};
  localparam int unsigned OP_B [NP] = '{8, 5, 2, 8, 5, 2, 5, 8, 8, 2, 2, 5, 7, 4, 1, 7, 4, 1};

  typedef struct packed {
    logic signed [EW-1:0] a00;
    logic signed [EW-1:0] a01;
    logic signed [EW-1:0] a02;
    logic signed [EW-1:0] a10;
    logic signed [EW-1:0] a11;
    logic signed [EW-1:0] a12;
    logic signed [EW-1:0] a20;
    logic signed [EW-1:0] a21;
    logic signed [EW-1:0] a22;
  } smi_in_t;

  typedef struct packed {
    logic signed [RW-1:0] r00;
    logic signed [RW-1:0] r01;
    logic signed [RW-1:0] r02;
    logic signed [RW-1:0] r10;
    logic signed [RW-1:0] r11;
    logic signed [RW-1:0] r12;
    logic signed [RW-1:0] r20;
    logic signed [RW-1:0] r21;
    logic signed [RW-1:0] r22;
    logic signed [DW-1:0] det_value;
    logic                 singular;
    logic                 saturated;
  } smi_out_t;

endpackage

FILE: sv/small_matrix_inverse_top.sv
// Top level of the 2x2/3x3 matrix inverse: cofactor front end, nine divider lanes, merge.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_stall_o   in_data_i  (smi_in_t)
//   out      output     out_valid_o / out_stall_i out_data_o (smi_out_t)
//   cfg      input      cfg_we_i                  cfg_wdata_i (matrix order)
//
// One request per cycle is accepted while the output is not stalled; it passes 41
// register stages: 5 cofactor and determinant stages, 35 lane stages (operand
// setup, 33 quotient bits, rounding) and the merge register.
// Reset clears the pipeline valid bits and sets the matrix order to 3.
// A stalled output freezes the whole pipeline; the first stage still takes a
// request while it is empty.
module small_matrix_inverse_top import smi_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  smi_in_t    in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output smi_out_t   out_data_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i
);

  localparam int unsigned FRONT = 5;
  localparam int unsigned DEPTH = FRONT + QW + 2;

  // Matrix order register.
  logic [1:0] order_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= ORDER_RESET;
    end else if (cfg_we_i) begin
      order_q <= cfg_wdata_i;
    end
  end

  // Pipeline advance and first-stage load.
  logic             en;
  logic             ld;
  logic [DEPTH-1:0] vld_q;

  assign en         = !(out_valid_o && out_stall_i);
  assign ld         = en || !vld_q[0];
  assign in_stall_o = !ld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (ld) begin
        vld_q[0] <= in_valid_i;
      end
      if (en) begin
        vld_q[DEPTH-1:1] <= vld_q[DEPTH-2:0];
      end
    end
  end

  // Cofactors and determinant.
  logic signed [CW-1:0] cof [NE];
  logic signed [DW-1:0] det;

  smi_cofactor u_cof (
    .clk_i     (clk_i),
    .ld_i      (ld),
    .en_i      (en),
    .in_data_i (in_data_i),
    .ord2_i    (order_q == ORDER_2X2),
    .cof_o     (cof),
    .det_o     (det)
  );

  // Nine divider lanes, one per inverse entry.
  logic [RW-1:0] res [NE];
  logic [NE-1:0] sat;

  for (genvar k = 0; k < NE; k++) begin : g_lane
    smi_div_lane u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .cof_i (cof[k]),
      .det_i (det),
      .res_o (res[k]),
      .sat_o (sat[k])
    );
  end

  smi_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vld_q[DEPTH-1]),
    .det_i   (det),
    .res_i   (res),
    .sat_i   (sat),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

endmodule

FILE: sv/smi_cofactor.sv
// Front end: registers the matrix, forms the nine cofactors and the exact determinant.
module smi_cofactor import smi_pkg::*; (
  input  logic                 clk_i,
  input  logic                 ld_i,
  input  logic                 en_i,
  input  smi_in_t              in_data_i,
  input  logic                 ord2_i,
  output logic signed [CW-1:0] cof_o [NE],
  output logic signed [DW-1:0] det_o
);

  // Stage 1: captured matrix.
  logic signed [EW-1:0] a1_q [NE];
  logic                 ord2_1_q;

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      a1_q[0]  <= in_data_i.a00;
      a1_q[1]  <= in_data_i.a01;
      a1_q[2]  <= in_data_i.a02;
      a1_q[3]  <= in_data_i.a10;
      a1_q[4]  <= in_data_i.a11;
      a1_q[5]  <= in_data_i.a12;
      a1_q[6]  <= in_data_i.a20;
      a1_q[7]  <= in_data_i.a21;
      a1_q[8]  <= in_data_i.a22;
      ord2_1_q <= ord2_i;
    end
  end

  // Stage 2: all two-term products of the 2x2 minors.
  logic signed [2*EW-1:0] prod_d [NP];
  logic signed [2*EW-1:0] prod_q [NP];
  logic signed [EW-1:0]   a2_q [NE];
  logic                   ord2_2_q;

  for (genvar k = 0; k < NP; k++) begin : g_prod
    assign prod_d[k] = a1_q[OP_A[k]] * a1_q[OP_B[k]];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q   <= prod_d;
      a2_q     <= a1_q;
      ord2_2_q <= ord2_1_q;
    end
  end

  // Stage 3: cofactors, chosen by matrix order.
  logic signed [CW-1:0] cof3_d [NE];
  logic signed [CW-1:0] cof3_q [NE];
  logic signed [DW-1:0] det2_q;
  logic signed [EW-1:0] a3_q [3];
  logic                 ord2_3_q;

  always_comb begin
    for (int k = 0; k < NE; k++) begin
      cof3_d[k] = CW'(prod_q[2*k]) - CW'(prod_q[2*k+1]);
    end
    if (ord2_2_q) begin
      for (int k = 0; k < NE; k++) begin
        cof3_d[k] = '0;
      end
      cof3_d[0] = CW'(a2_q[4]) <<< EF;
      cof3_d[1] = -(CW'(a2_q[1]) <<< EF);
      cof3_d[3] = -(CW'(a2_q[3]) <<< EF);
      cof3_d[4] = CW'(a2_q[0]) <<< EF;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cof3_q   <= cof3_d;
      det2_q   <= (DW'(prod_q[16]) - DW'(prod_q[17])) <<< EF;
      a3_q[0]  <= a2_q[0];
      a3_q[1]  <= a2_q[1];
      a3_q[2]  <= a2_q[2];
      ord2_3_q <= ord2_2_q;
    end
  end

  // Stage 4: first-row expansion terms.
  logic signed [TW-1:0] term_q [3];
  logic signed [CW-1:0] cof4_q [NE];
  logic signed [DW-1:0] det2_4_q;
  logic                 ord2_4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      term_q[0] <= a3_q[0] * cof3_q[0];
      term_q[1] <= a3_q[1] * cof3_q[3];
      term_q[2] <= a3_q[2] * cof3_q[6];
      cof4_q    <= cof3_q;
      det2_4_q  <= det2_q;
      ord2_4_q  <= ord2_3_q;
    end
  end

  // Stage 5: determinant.
  logic signed [CW-1:0] cof5_q [NE];
  logic signed [DW-1:0] det5_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cof5_q <= cof4_q;
      det5_q <= ord2_4_q ? det2_4_q
                         : DW'(term_q[0]) + DW'(term_q[1]) + DW'(term_q[2]);
    end
  end

  assign cof_o = cof5_q;
  assign det_o = det5_q;

endmodule

FILE: sv/smi_div_lane.sv
// One divider lane: rounded, saturated cofactor over determinant, one quotient bit per stage.
module smi_div_lane import smi_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [CW-1:0] cof_i,
  input  logic signed [DW-1:0] det_i,
  output logic        [RW-1:0] res_o,
  output logic                 sat_o
);

  localparam int unsigned XW = DW + QW;
  localparam logic [QW:0] MAX_POS = (QW+1)'((65'd1 << (RW - 1)) - 65'd1);
  localparam logic [QW:0] MAX_NEG = (QW+1)'(65'd1 << (RW - 1));

  logic [NW-1:0] r_q   [QW+1];
  logic [QW-1:0] q_q   [QW+1];
  logic [DW-1:0] d_q   [QW+1];
  logic          neg_q [QW+1];
  logic          ovf_q [QW+1];

  // Prepare magnitudes and catch quotients too large for the iterations.
  logic [CW-1:0] cof_mag;
  logic [DW-1:0] det_mag;
  logic [NW-1:0] num_mag;

  assign cof_mag = cof_i[CW-1] ? CW'(-cof_i) : CW'(cof_i);
  assign det_mag = det_i[DW-1] ? DW'(-det_i) : DW'(det_i);
  assign num_mag = NW'(cof_mag) << (EF + RF);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= num_mag;
      q_q[0]   <= '0;
      d_q[0]   <= det_mag;
      neg_q[0] <= cof_i[CW-1] ^ det_i[DW-1];
      ovf_q[0] <= XW'(num_mag) >= (XW'(det_mag) << QW);
    end
  end

  // Restoring division, most significant quotient bit first.
  for (genvar j = 1; j <= QW; j++) begin : g_step
    localparam int unsigned BIT = QW - j;
    logic [XW-1:0] trial;
    logic          take;

    assign trial = XW'(d_q[j-1]) << BIT;
    assign take  = XW'(r_q[j-1]) >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[j]   <= take ? NW'(XW'(r_q[j-1]) - trial) : r_q[j-1];
        q_q[j]   <= q_q[j-1] | (QW'(take) << BIT);
        d_q[j]   <= d_q[j-1];
        neg_q[j] <= neg_q[j-1];
        ovf_q[j] <= ovf_q[j-1];
      end
    end
  end

  // Round half away from zero, then clip to the result range.
  logic          rnd;
  logic [QW:0]   q_rnd;
  logic          sat_d;
  logic [RW-1:0] res_d;

  always_comb begin
    rnd   = (XW'(r_q[QW]) << 1) >= XW'(d_q[QW]);
    q_rnd = {1'b0, q_q[QW]} + (QW+1)'(rnd);
    if (neg_q[QW]) begin
      sat_d = ovf_q[QW] || (q_rnd > MAX_NEG);
      res_d = sat_d ? {1'b1, {(RW-1){1'b0}}} : RW'(-q_rnd);
    end else begin
      sat_d = ovf_q[QW] || (q_rnd > MAX_POS);
      res_d = sat_d ? {1'b0, {(RW-1){1'b1}}} : RW'(q_rnd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o <= res_d;
      sat_o <= sat_d;
    end
  end

endmodule

FILE: sv/smi_merge.sv
// Merge stage: aligns the determinant with the lanes and builds the output register.
module smi_merge import smi_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [DW-1:0] det_i,
  input  logic        [RW-1:0] res_i [NE],
  input  logic        [NE-1:0] sat_i,
  output logic                 valid_o,
  output smi_out_t             data_o
);

  // The determinant waits as long as a lane takes.
  localparam int unsigned LAT = QW + 2;

  logic signed [DW-1:0] det_q [LAT];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      det_q[0] <= det_i;
      for (int k = 1; k < LAT; k++) begin
        det_q[k] <= det_q[k-1];
      end
    end
  end

  // A zero determinant forces the zero inverse and clears the clip flag.
  logic     sing;
  smi_out_t out_d;

  always_comb begin
    sing            = det_q[LAT-1] == '0;
    out_d.r00       = sing ? '0 : res_i[0];
    out_d.r01       = sing ? '0 : res_i[1];
    out_d.r02       = sing ? '0 : res_i[2];
    out_d.r10       = sing ? '0 : res_i[3];
    out_d.r11       = sing ? '0 : res_i[4];
    out_d.r12       = sing ? '0 : res_i[5];
    out_d.r20       = sing ? '0 : res_i[6];
    out_d.r21       = sing ? '0 : res_i[7];
    out_d.r22       = sing ? '0 : res_i[8];
    out_d.det_value = det_q[LAT-1];
    out_d.singular  = sing;
    out_d.saturated = !sing && (|sat_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_o <= out_d;
    end
  end

endmodule

FILE: sv/smi_checker.sv
// Port-level checks of the matrix inverse top level, bound to it.
module smi_checker import smi_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input smi_in_t    in_data_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input smi_out_t   out_data_o,
  input logic       cfg_we_i,
  input logic [1:0] cfg_wdata_i
);

  // A singular result carries a zero determinant, no clip and zero diagonal inverse entries.
  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.singular |->
      out_data_o.det_value == '0 && !out_data_o.saturated && out_data_o.r00 == '0 &&
      out_data_o.r11 == '0 && out_data_o.r22 == '0)
    else $error("singular result not cleared");

  // A nonsingular result has a nonzero determinant.
  a_nonsingular_det: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.singular |-> out_data_o.det_value != '0)
    else $error("nonsingular result with zero determinant");

  // With no result waiting, the block never stalls a request.
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind small_matrix_inverse_top smi_checker u_smi_checker (.*);

FILE: tb/sv/small_matrix_inverse_top_tb.sv
// Self-checking testbench for the small matrix inverse block: directed table, then random traffic.
module small_matrix_inverse_top_tb;
  import smi_pkg::*;

  localparam int unsigned OUT_BITS = $bits(smi_out_t);
  localparam int unsigned IN_BITS = $bits(smi_in_t);
  localparam int unsigned PIPE_DEPTH = 41;
  localparam int unsigned RAND_PER_PHASE = 180;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  smi_in_t    in_data_i;
  logic       out_valid_o;
  logic       out_stall_i;
  smi_out_t   out_data_o;
  logic       cfg_we_i;
  logic [1:0] cfg_wdata_i;

  small_matrix_inverse_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // One row of the directed table.
  typedef struct {
    logic [1:0] order;
    smi_in_t    mat;
    bit         typed;
    smi_out_t   result;
  } dir_row_t;

  smi_out_t   inverse_q [$];
  dir_row_t   dir_rows [$];
  logic [1:0] order_reg;
  int         err_cnt;
  int         req_cnt;
  int         res_cnt;
  int         singular_cnt;
  int         clipped_cnt;
  int         burst_left;
  bit         hold_go;
  bit         hold_done;

  // Clock: period 20.
  initial begin
    clk_i = 1'b0;
  end
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Signed 16-bit entry extended to a 64-bit two's complement pattern.
  function automatic logic [63:0] widen(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // Rounded (ties away from zero) and saturated quotient in Q16.16.
  function automatic logic [RW-1:0] quot_sat(logic [63:0] num, logic [63:0] den, inout bit sat);
    logic [63:0] n;
    logic [63:0] d;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] maxp;
    bit          neg;
    n = num[63] ? -num : num;
    d = den[63] ? -den : den;
    q = n / d;
    r = n % d;
    maxp = 64'h7FFF_FFFF;
    neg = num[63] != den[63];
    if (r >= d - r) q = q + 1;
    if (!neg && q > maxp) begin
      q = maxp;
      sat = 1'b1;
    end else if (neg && q > maxp + 1) begin
      q = maxp + 1;
      sat = 1'b1;
    end
    q = neg ? -q : q;
    return q[RW-1:0];
  endfunction

  // Determinant and adjugate-over-determinant inverse for the given order.
  function automatic smi_out_t inverse_of(smi_in_t m, logic [1:0] ord);
    logic [63:0] a [9];
    logic [63:0] cof [9];
    logic [63:0] det;
    logic [RW-1:0] r [9];
    bit sat;
    smi_out_t o;
    sat = 1'b0;
    a[0] = widen(m.a00); a[1] = widen(m.a01); a[2] = widen(m.a02);
    a[3] = widen(m.a10); a[4] = widen(m.a11); a[5] = widen(m.a12);
    a[6] = widen(m.a20); a[7] = widen(m.a21); a[8] = widen(m.a22);
    if (ord == ORDER_2X2) begin
      for (int i = 0; i < 9; i++) cof[i] = '0;
      cof[0] = a[4] << EF;
      cof[1] = (-a[1]) << EF;
      cof[3] = (-a[3]) << EF;
      cof[4] = a[0] << EF;
      det = (a[0] * a[4] - a[1] * a[3]) << EF;
    end else begin
      cof[0] = a[4] * a[8] - a[7] * a[5];
      cof[1] = -(a[1] * a[8] - a[7] * a[2]);
      cof[2] = a[1] * a[5] - a[4] * a[2];
      cof[3] = -(a[3] * a[8] - a[6] * a[5]);
      cof[4] = a[0] * a[8] - a[6] * a[2];
      cof[5] = -(a[0] * a[5] - a[3] * a[2]);
      cof[6] = a[3] * a[7] - a[6] * a[4];
      cof[7] = -(a[0] * a[7] - a[6] * a[1]);
      cof[8] = a[0] * a[4] - a[3] * a[1];
      det = a[0] * cof[0] + a[1] * cof[3] + a[2] * cof[6];
    end
    o = '0;
    if (det == 0) begin
      o.singular = 1'b1;
      return o;
    end
    for (int i = 0; i < 9; i++) begin
      r[i] = (cof[i] == 0) ? '0 : quot_sat(cof[i] << (EF + RF), det, sat);
    end
    o.r00 = r[0]; o.r01 = r[1]; o.r02 = r[2];
    o.r10 = r[3]; o.r11 = r[4]; o.r12 = r[5];
    o.r20 = r[6]; o.r21 = r[7]; o.r22 = r[8];
    o.det_value = det[DW-1:0];
    o.saturated = sat;
    return o;
  endfunction

  function automatic smi_in_t mat_of(int e0, int e1, int e2, int e3, int e4, int e5,
                                     int e6, int e7, int e8);
    smi_in_t m;
    m.a00 = 16'(e0); m.a01 = 16'(e1); m.a02 = 16'(e2);
    m.a10 = 16'(e3); m.a11 = 16'(e4); m.a12 = 16'(e5);
    m.a20 = 16'(e6); m.a21 = 16'(e7); m.a22 = 16'(e8);
    return m;
  endfunction

  task automatic add_row(logic [1:0] ord, smi_in_t m, bit typed, smi_out_t res);
    dir_row_t row;
    row.order = ord;
    row.mat = m;
    row.typed = typed;
    row.result = res;
    dir_rows.push_back(row);
  endtask

  // Random matrix: full range, small values, singular, extremes or near-singular.
  function automatic smi_in_t random_mat();
    smi_in_t m;
    logic [15:0] ext [6];
    int mode;
    ext[0] = 16'h7FFF; ext[1] = 16'h8000; ext[2] = 16'h0000;
    ext[3] = 16'h0100; ext[4] = 16'hFF00; ext[5] = 16'h0001;
    mode = $urandom_range(0, 9);
    m = '0;
    if (mode <= 2) begin
      m = IN_BITS'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
    end else if (mode <= 6) begin
      m = mat_of($urandom_range(0, 2048) - 1024, $urandom_range(0, 512) - 256,
                 $urandom_range(0, 512) - 256, $urandom_range(0, 512) - 256,
                 $urandom_range(0, 2048) - 1024, $urandom_range(0, 512) - 256,
                 $urandom_range(0, 512) - 256, $urandom_range(0, 512) - 256,
                 $urandom_range(0, 2048) - 1024);
    end else if (mode == 7) begin
      // Two equal rows force a zero determinant in either order.
      m = IN_BITS'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
      m.a10 = m.a00; m.a11 = m.a01; m.a12 = m.a02;
    end else if (mode == 8) begin
      m = mat_of(ext[$urandom_range(0, 5)], ext[$urandom_range(0, 5)],
                 ext[$urandom_range(0, 5)], ext[$urandom_range(0, 5)],
                 ext[$urandom_range(0, 5)], ext[$urandom_range(0, 5)],
                 ext[$urandom_range(0, 5)], ext[$urandom_range(0, 5)],
                 ext[$urandom_range(0, 5)]);
    end else begin
      // Tiny determinant with larger off-diagonal terms drives saturation.
      m = mat_of($urandom_range(1, 4), $urandom(), $urandom_range(0, 64),
                 $urandom_range(0, 8), $urandom_range(1, 4), $urandom(),
                 $urandom_range(0, 8), $urandom_range(0, 8), $urandom_range(1, 4));
    end
    return m;
  endfunction

  // Offer one request, bursting with random gaps; record the result on acceptance.
  task automatic send_request(smi_in_t m, bit typed, smi_out_t res);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i <= m;
    do @(posedge clk_i); while (in_stall_o);
    inverse_q.push_back(typed ? res : inverse_of(m, order_reg));
    req_cnt++;
    if (req_cnt == 400) hold_go = 1'b1;
  endtask

  // Drain the pipeline, then write the order register.
  task automatic set_order(logic [1:0] v);
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (inverse_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    order_reg = (v == 2'd2) ? ORDER_2X2 : ORDER_RESET;
  endtask

  // Output stall: its own random pattern plus one long hold-off.
  initial begin
    int mode;
    int run;
    out_stall_i = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
      end
      mode = $urandom_range(0, 3);
      run = $urandom_range(5, 40);
      repeat (run) begin
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= $urandom_range(0, 1);
          default: out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    logic [OUT_BITS-1:0] e;
    logic [OUT_BITS-1:0] g;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (inverse_q.size() == 0) begin
        $error("unexpected result %h", out_data_o);
        err_cnt++;
      end else begin
        e = inverse_q.pop_front();
        g = out_data_o;
        for (int k = 0; k < 9; k++) begin
          if (e[OUT_BITS-1-32*k -: 32] !== g[OUT_BITS-1-32*k -: 32]) begin
            $error("r%0d%0d expected %h actual %h", k / 3, k % 3,
                   e[OUT_BITS-1-32*k -: 32], g[OUT_BITS-1-32*k -: 32]);
            err_cnt++;
          end
        end
        if (e[53:2] !== g[53:2]) begin
          $error("det_value expected %h actual %h", e[53:2], g[53:2]);
          err_cnt++;
        end
        if (e[1] !== g[1]) begin
          $error("singular expected %b actual %b", e[1], g[1]);
          err_cnt++;
        end
        if (e[0] !== g[0]) begin
          $error("saturated expected %b actual %b", e[0], g[0]);
          err_cnt++;
        end
        res_cnt++;
        singular_cnt += g[1];
        clipped_cnt += g[0];
      end
    end
  end

  // Watchdog.
  initial begin
    #(20 * 400000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Main sequence.
  initial begin
    smi_out_t res;
    smi_out_t none;
    logic [1:0] phase_order [5];
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    err_cnt = 0;
    req_cnt = 0;
    res_cnt = 0;
    singular_cnt = 0;
    clipped_cnt = 0;
    burst_left = 0;
    hold_go = 1'b0;
    order_reg = ORDER_RESET;
    none = '0;

    // Directed rows; the order after reset is 3.
    res = '0;
    res.r00 = 32'h0001_0000; res.r11 = 32'h0001_0000; res.r22 = 32'h0001_0000;
    res.det_value = 52'h100_0000;
    add_row(2'd3, mat_of(256, 0, 0, 0, 256, 0, 0, 0, 256), 1'b1, res);
    res = '0;
    res.singular = 1'b1;
    add_row(2'd3, '0, 1'b1, res);
    add_row(2'd3, mat_of(32767, 0, 0, 0, 32767, 0, 0, 0, 32767), 1'b0, none);
    add_row(2'd3, mat_of(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768), 1'b0, none);
    add_row(2'd3, mat_of(32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, -1),
            1'b0, none);
    add_row(2'd3, mat_of(1, 2, 3, 1, 2, 3, 7, -9, 4), 1'b0, none);
    add_row(2'd3, mat_of(1, 32767, 0, 0, 1, 0, 0, 0, 1), 1'b0, none);
    add_row(2'd3, mat_of(1, -32768, 32767, 0, 1, -32768, 0, 0, 1), 1'b0, none);
    add_row(2'd3, mat_of(300, 17, -40, 5, -700, 80, 9, 33, 512), 1'b0, none);
    res = '0;
    res.r00 = 32'h0001_0000; res.r11 = 32'h0001_0000;
    res.det_value = 52'h100_0000;
    add_row(2'd2, mat_of(256, 0, 1234, 0, 256, -999, 77, 88, 99), 1'b1, res);
    res = '0;
    res.singular = 1'b1;
    add_row(2'd2, mat_of(0, 0, 5, 0, 0, 6, 7, 8, 9), 1'b1, res);
    add_row(2'd2, mat_of(32767, 32767, 0, -32768, 32767, 0, 0, 0, 0), 1'b0, none);
    add_row(2'd2, mat_of(-32768, -32768, 1, -32768, -32768, 1, 1, 1, 1), 1'b0, none);
    add_row(2'd2, mat_of(1, 32767, 0, 0, 1, 0, 0, 0, 0), 1'b0, none);
    add_row(2'd2, mat_of(1, -32768, 0, 32767, 1, 0, 0, 0, 0), 1'b0, none);
    add_row(2'd2, mat_of(512, 3, 0, -7, 384, 0, 0, 0, 0), 1'b0, none);
    add_row(2'd0, mat_of(256, 0, 0, 0, 256, 0, 0, 0, 256), 1'b0, none);
    add_row(2'd0, mat_of(100, 20, 3, -4, 50, 6, 7, 8, -90), 1'b0, none);
    add_row(2'd1, mat_of(-256, 1, 2, 3, 256, 4, 5, 6, 128), 1'b0, none);
    add_row(2'd3, mat_of(256, 0, 0, 0, 256, 0, 0, 0, 256), 1'b0, none);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table, changing order only when idle.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].order != order_reg || (i > 0 && dir_rows[i].order != dir_rows[i-1].order))
        set_order(dir_rows[i].order);
      send_request(dir_rows[i].mat, dir_rows[i].typed, dir_rows[i].result);
    end

    // Random phases over every register value.
    phase_order[0] = 2'd3; phase_order[1] = 2'd2; phase_order[2] = 2'd0;
    phase_order[3] = 2'd1; phase_order[4] = 2'd2;
    foreach (phase_order[p]) begin
      set_order(phase_order[p]);
      repeat (RAND_PER_PHASE) send_request(random_mat(), 1'b0, none);
    end
    in_valid_i <= 1'b0;

    // Drain, then wait for any stray results.
    while (inverse_q.size() != 0) @(posedge clk_i);
    repeat (3 * PIPE_DEPTH) @(posedge clk_i);

    $display("Sent %0d matrices in orders 2 and 3 (register values 0-3), with a long output hold.",
             req_cnt);
    $display("Checked %0d results: %0d singular, %0d saturated.", res_cnt, singular_cnt,
             clipped_cnt);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
